@@ sv/convex_hull_2d_monotone_chain_top_assert.svh @@
// assertion macros for the hull block checker
`ifndef CONVEX_HULL_2D_MONOTONE_CHAIN_TOP_ASSERT_SVH
`define CONVEX_HULL_2D_MONOTONE_CHAIN_TOP_ASSERT_SVH

// same-cycle implication
`define CH_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hull checker: same-cycle rule broken");

// next-cycle implication
`define CH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hull checker: next-cycle rule broken");

`endif

@@ sv/ch2d_pkg.sv @@
package ch2d_pkg;

  localparam int MaxPoints = 64;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = IdxW + 1;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] hull_index;
    logic            last_vertex;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RI,
    ST_LI,
    ST_RJ,
    ST_CJ,
    ST_FIN,
    ST_C_RO,
    ST_C_RP,
    ST_C_LP,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_PUSH,
    ST_POP,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_E_RD,
    ST_E_OUT,
    ST_SGL_RD,
    ST_SGL_OUT
  } st_e;

endpackage

@@ sv/convex_hull_2d_monotone_chain_top.sv @@
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+------------------------------
// point    | in        | start high, busy low  | item_i  (px, py, last_point)
// hull     | out       | strobe_o, one cycle   | result_o (hull_index, last_vertex)
//
// a point without last_point is stored, if the store has room, and busy stays low
// the last point runs the hull over the n held points: it marks coincident
// points and ranks the rest, then builds each chain by pushes and pops on
// the shared multiplier and emits the vertices of that chain
// reset clears the sequencer, point count and strobe; the stores hold no reset
// the receiver cannot stall, each result shows for one cycle only
module convex_hull_2d_monotone_chain_top
  import ch2d_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      strobe_o,
  output out_item_t result_o
);

  // point stores and working lists
  logic signed [15:0] xmem [MaxPoints];
  logic signed [15:0] ymem [MaxPoints];
  logic [IdxW-1:0]    ordmem [MaxPoints];
  logic [IdxW-1:0]    stkmem [MaxPoints];

  st_e state_q, state_d;

  logic [CntW-1:0] cnt_q, cnt_d, n_q, n_d, m_q, m_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d, t_q, t_d, s_q, s_d, e_q, e_d;
  logic [IdxW-1:0] rank_q, rank_d;
  logic            found_q, found_d, pass_q, pass_d, upper_q, upper_d;
  logic [MaxPoints-1:0] dup_q, dup_d;

  // candidate point of the scans and of the chain
  logic signed [15:0] pix_q, pix_d, piy_q, piy_d;
  logic signed [15:0] pcx_q, pcx_d, pcy_q, pcy_d;
  logic signed [15:0] topx_q, topx_d, topy_q, topy_d;
  logic signed [15:0] secx_q, secx_d, secy_q, secy_d;
  logic [IdxW-1:0]    p_i_q, p_i_d, top_i_q, top_i_d, sec_i_q, sec_i_d;
  logic signed [33:0] prod1_q, prod1_d, prod2_q, prod2_d;

  // registered read ports
  logic signed [15:0] rx_q, ry_q;
  logic [IdxW-1:0]    ord_rd_q, stk_rd_q;
  logic [IdxW-1:0]    xy_addr, ord_addr, stk_addr;

  // write ports
  logic            xy_we, ord_we, stk_we;
  logic [IdxW-1:0] xy_wa, ord_wa, stk_wa, ord_wd, stk_wd;

  logic            strobe_q, strobe_d;
  out_item_t       res_q, res_d;

  // shared multiplier
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;

  logic [CntW-1:0] limit;
  logic            i_last, eq_ji, before_ji;
  logic signed [16:0] dax, day, dcx, dcy;

  assign mul_p = mul_a * mul_b;

  assign limit  = pass_q ? n_q : i_q;
  assign i_last = (i_q + CntW'(1)) == n_q;
  assign eq_ji  = (rx_q == pix_q) && (ry_q == piy_q);
  assign before_ji = (rx_q < pix_q) || ((rx_q == pix_q) && (ry_q > piy_q)) ||
                     (eq_ji && (j_q < i_q));

  // difference vectors about the stack top
  assign dax = 17'(pcx_q) - 17'(topx_q);
  assign day = 17'(pcy_q) - 17'(topy_q);
  assign dcx = 17'(secx_q) - 17'(topx_q);
  assign dcy = 17'(secy_q) - 17'(topy_q);

  assign busy     = state_q != ST_IDLE;
  assign strobe_o = strobe_q;
  assign result_o = res_q;

  always_ff @(posedge clk_i) begin
    if (xy_we) begin
      xmem[xy_wa] <= item_i.px;
      ymem[xy_wa] <= item_i.py;
    end
    rx_q <= xmem[xy_addr];
    ry_q <= ymem[xy_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ordmem[ord_wa] <= ord_wd;
    end
    ord_rd_q <= ordmem[ord_addr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stkmem[stk_wa] <= stk_wd;
    end
    stk_rd_q <= stkmem[stk_addr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
    end
  end

  // working registers, written before they are read
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    m_q     <= m_d;
    i_q     <= i_d;
    j_q     <= j_d;
    t_q     <= t_d;
    s_q     <= s_d;
    e_q     <= e_d;
    rank_q  <= rank_d;
    found_q <= found_d;
    pass_q  <= pass_d;
    upper_q <= upper_d;
    dup_q   <= dup_d;
    pix_q   <= pix_d;
    piy_q   <= piy_d;
    pcx_q   <= pcx_d;
    pcy_q   <= pcy_d;
    topx_q  <= topx_d;
    topy_q  <= topy_d;
    secx_q  <= secx_d;
    secy_q  <= secy_d;
    p_i_q   <= p_i_d;
    top_i_q <= top_i_d;
    sec_i_q <= sec_i_d;
    prod1_q <= prod1_d;
    prod2_q <= prod2_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    m_d      = m_q;
    i_d      = i_q;
    j_d      = j_q;
    t_d      = t_q;
    s_d      = s_q;
    e_d      = e_q;
    rank_d   = rank_q;
    found_d  = found_q;
    pass_d   = pass_q;
    upper_d  = upper_q;
    dup_d    = dup_q;
    pix_d    = pix_q;
    piy_d    = piy_q;
    pcx_d    = pcx_q;
    pcy_d    = pcy_q;
    topx_d   = topx_q;
    topy_d   = topy_q;
    secx_d   = secx_q;
    secy_d   = secy_q;
    p_i_d    = p_i_q;
    top_i_d  = top_i_q;
    sec_i_d  = sec_i_q;
    prod1_d  = prod1_q;
    prod2_d  = prod2_q;
    res_d    = res_q;
    strobe_d = 1'b0;
    xy_addr  = '0;
    ord_addr = '0;
    stk_addr = '0;
    xy_we    = 1'b0;
    xy_wa    = cnt_q[IdxW-1:0];
    ord_we   = 1'b0;
    ord_wa   = rank_q;
    ord_wd   = i_q[IdxW-1:0];
    stk_we   = 1'b0;
    stk_wa   = s_q[IdxW-1:0];
    stk_wd   = p_i_q;
    mul_a    = dax;
    mul_b    = dcy;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          // a full store drops the point
          if (!cnt_q[IdxW]) begin
            xy_we = 1'b1;
            cnt_d = cnt_q + CntW'(1);
          end
          if (item_i.last_point) begin
            n_d     = cnt_q[IdxW] ? cnt_q : cnt_q + CntW'(1);
            cnt_d   = '0;
            i_d     = '0;
            m_d     = '0;
            pass_d  = 1'b0;
            state_d = ST_RI;
          end
        end
      end
      // pass one marks coincident points, pass two ranks the survivors
      ST_RI: begin
        xy_addr = i_q[IdxW-1:0];
        if (pass_q && dup_q[i_q[IdxW-1:0]]) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_LI;
        end
      end
      ST_LI: begin
        pix_d   = rx_q;
        piy_d   = ry_q;
        j_d     = '0;
        found_d = 1'b0;
        rank_d  = '0;
        state_d = (limit == '0) ? ST_FIN : ST_RJ;
      end
      ST_RJ: begin
        xy_addr = j_q[IdxW-1:0];
        state_d = ST_CJ;
      end
      ST_CJ: begin
        if (!pass_q) begin
          if (eq_ji) begin
            found_d = 1'b1;
          end
        end else if (!dup_q[j_q[IdxW-1:0]] && before_ji) begin
          rank_d = rank_q + IdxW'(1);
        end
        j_d     = j_q + CntW'(1);
        state_d = ((j_q + CntW'(1)) == limit) ? ST_FIN : ST_RJ;
      end
      ST_FIN: begin
        if (!pass_q) begin
          dup_d[i_q[IdxW-1:0]] = found_q;
          if (!found_q) begin
            m_d = m_q + CntW'(1);
          end
        end else if (!dup_q[i_q[IdxW-1:0]]) begin
          ord_we = 1'b1;
        end
        if (i_last) begin
          i_d = '0;
          if (!pass_q) begin
            pass_d  = 1'b1;
            state_d = ST_RI;
          end else if (m_q == CntW'(1)) begin
            state_d = ST_SGL_RD;
          end else begin
            upper_d = 1'b0;
            t_d     = '0;
            s_d     = '0;
            state_d = ST_C_RO;
          end
        end else begin
          i_d     = i_q + CntW'(1);
          state_d = ST_RI;
        end
      end
      // chain build over the sorted list, forward then backward
      ST_C_RO: begin
        if (t_q == m_q) begin
          e_d     = '0;
          state_d = ST_E_RD;
        end else begin
          ord_addr = upper_q ? IdxW'(m_q - CntW'(1) - t_q) : t_q[IdxW-1:0];
          state_d  = ST_C_RP;
        end
      end
      ST_C_RP: begin
        xy_addr = ord_rd_q;
        p_i_d   = ord_rd_q;
        state_d = ST_C_LP;
      end
      ST_C_LP: begin
        pcx_d   = rx_q;
        pcy_d   = ry_q;
        state_d = (s_q >= CntW'(2)) ? ST_M1 : ST_PUSH;
      end
      ST_M1: begin
        mul_a   = dax;
        mul_b   = dcy;
        prod1_d = mul_p;
        state_d = ST_M2;
      end
      ST_M2: begin
        mul_a   = day;
        mul_b   = dcx;
        prod2_d = mul_p;
        state_d = ST_M3;
      end
      ST_M3: begin
        // strictly positive turn keeps the top
        state_d = (prod1_q > prod2_q) ? ST_PUSH : ST_POP;
      end
      ST_PUSH: begin
        stk_we  = 1'b1;
        sec_i_d = top_i_q;
        secx_d  = topx_q;
        secy_d  = topy_q;
        top_i_d = p_i_q;
        topx_d  = pcx_q;
        topy_d  = pcy_q;
        s_d     = s_q + CntW'(1);
        t_d     = t_q + CntW'(1);
        state_d = ST_C_RO;
      end
      ST_POP: begin
        s_d     = s_q - CntW'(1);
        top_i_d = sec_i_q;
        topx_d  = secx_q;
        topy_d  = secy_q;
        state_d = ((s_q - CntW'(1)) >= CntW'(2)) ? ST_P1 : ST_PUSH;
      end
      ST_P1: begin
        stk_addr = IdxW'(s_q - CntW'(2));
        state_d  = ST_P2;
      end
      ST_P2: begin
        xy_addr = stk_rd_q;
        sec_i_d = stk_rd_q;
        state_d = ST_P3;
      end
      ST_P3: begin
        secx_d  = rx_q;
        secy_d  = ry_q;
        state_d = ST_M1;
      end
      // emit all chain vertices but the final one
      ST_E_RD: begin
        if ((e_q + CntW'(1)) >= s_q) begin
          if (upper_q) begin
            state_d = ST_IDLE;
          end else begin
            upper_d = 1'b1;
            t_d     = '0;
            s_d     = '0;
            state_d = ST_C_RO;
          end
        end else begin
          stk_addr = e_q[IdxW-1:0];
          state_d  = ST_E_OUT;
        end
      end
      ST_E_OUT: begin
        strobe_d          = 1'b1;
        res_d.hull_index  = stk_rd_q;
        res_d.last_vertex = upper_q && ((e_q + CntW'(2)) == s_q);
        e_d               = e_q + CntW'(1);
        state_d           = ST_E_RD;
      end
      ST_SGL_RD: begin
        ord_addr = '0;
        state_d  = ST_SGL_OUT;
      end
      ST_SGL_OUT: begin
        strobe_d          = 1'b1;
        res_d.hull_index  = ord_rd_q;
        res_d.last_vertex = 1'b1;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/ch2d_chk.sv @@
`include "convex_hull_2d_monotone_chain_top_assert.svh"

module ch2d_chk
  import ch2d_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input in_item_t  item_i,
  input logic      strobe_o,
  input out_item_t result_o
);

  `CH_ASSERT_NEXT(a_last_goes_busy, start && !busy && item_i.last_point, busy)
  `CH_ASSERT_NEXT(a_load_stays_free, start && !busy && !item_i.last_point, !busy)
  `CH_ASSERT_NEXT(a_strobe_spaced, strobe_o, !strobe_o)
  `CH_ASSERT_SAME(a_mid_result_busy, strobe_o && !result_o.last_vertex, busy)

endmodule

bind convex_hull_2d_monotone_chain_top ch2d_chk u_ch2d_chk (.*);

@@ tb/convex_hull_2d_monotone_chain_checker.sv @@
// watches both channels, predicts the hull of each set and compares results
module convex_hull_2d_monotone_chain_checker
  import ch2d_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  item_i,
  input  logic      strobe_o,
  input  out_item_t result_o,
  output int        fail_count,
  output int        pending
);

  logic signed [15:0] px_mem [MaxPoints];
  logic signed [15:0] py_mem [MaxPoints];
  int                 n_held;
  out_item_t          hull_q [$];

  // x up, y down, load order up
  function automatic bit precedes(int a, int b);
    if (px_mem[a] != px_mem[b]) return px_mem[a] < px_mem[b];
    if (py_mem[a] != py_mem[b]) return py_mem[a] > py_mem[b];
    return a < b;
  endfunction

  // middle point j survives between k and the new point i
  function automatic bit turns_left(int i, int j, int k);
    longint a, b, c, d;
    a = longint'(px_mem[i]) - longint'(px_mem[j]);
    b = longint'(py_mem[i]) - longint'(py_mem[j]);
    c = longint'(px_mem[k]) - longint'(px_mem[j]);
    d = longint'(py_mem[k]) - longint'(py_mem[j]);
    return a * d - b * c > 0;
  endfunction

  function automatic void push_chain(int sorted_pts [$], bit reverse);
    int stk [$];
    int p;
    out_item_t r;
    for (int t = 0; t < sorted_pts.size(); t++) begin
      p = reverse ? sorted_pts[sorted_pts.size() - 1 - t] : sorted_pts[t];
      while (stk.size() >= 2 && !turns_left(p, stk[stk.size() - 1], stk[stk.size() - 2]))
        void'(stk.pop_back());
      stk.push_back(p);
    end
    for (int t = 0; t + 1 < stk.size(); t++) begin
      r.hull_index  = stk[t][IdxW-1:0];
      r.last_vertex = 1'b0;
      hull_q.push_back(r);
    end
  endfunction

  function automatic void predict_hull(int n);
    int ord [$];
    int uniq [$];
    int j;
    int first_new;
    out_item_t r;
    for (int i = 0; i < n; i++) begin
      j = 0;
      while (j < ord.size() && !precedes(i, ord[j])) j++;
      ord.insert(j, i);
    end
    foreach (ord[i]) begin
      if (uniq.size() > 0 && px_mem[ord[i]] == px_mem[uniq[uniq.size() - 1]] &&
          py_mem[ord[i]] == py_mem[uniq[uniq.size() - 1]])
        continue;
      uniq.push_back(ord[i]);
    end
    if (uniq.size() == 1) begin
      r.hull_index  = uniq[0][IdxW-1:0];
      r.last_vertex = 1'b1;
      hull_q.push_back(r);
      return;
    end
    first_new = hull_q.size();
    push_chain(uniq, 1'b0);
    push_chain(uniq, 1'b1);
    if (hull_q.size() > first_new) hull_q[hull_q.size() - 1].last_vertex = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_held     <= 0;
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (strobe_o) begin
        if (hull_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected hull item: index %0d last %0b",
                     result_o.hull_index, result_o.last_vertex);
          fail_count <= fail_count + 1;
        end else begin
          if (result_o !== hull_q[0]) begin
            if (fail_count < 10)
              $display("hull item mismatch: expected index %0d last %0b, got index %0d last %0b",
                       hull_q[0].hull_index, hull_q[0].last_vertex,
                       result_o.hull_index, result_o.last_vertex);
            fail_count <= fail_count + 1;
          end
          void'(hull_q.pop_front());
        end
      end
      if (start && !busy) begin
        // blocking updates of the store so the hull sees this point
        if (n_held < MaxPoints) begin
          px_mem[n_held] = item_i.px;
          py_mem[n_held] = item_i.py;
        end
        if (item_i.last_point) begin
          predict_hull(n_held < MaxPoints ? n_held + 1 : n_held);
          n_held <= 0;
        end else if (n_held < MaxPoints) begin
          n_held <= n_held + 1;
        end
      end
      // items still owed, after this edge's pops and predictions
      pending <= hull_q.size();
    end
  end

endmodule

@@ tb/convex_hull_2d_monotone_chain_top_tb.sv @@
// stimulus and verdict for the hull block, checking lives in the checker
module convex_hull_2d_monotone_chain_top_tb;
  import ch2d_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_item_t  item_i;
  logic      strobe_o;
  out_item_t result_o;
  int        fail_count;
  int        pending;
  int        n_sent;
  int        idle_pct;

  convex_hull_2d_monotone_chain_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .strobe_o(strobe_o),
    .result_o(result_o)
  );

  convex_hull_2d_monotone_chain_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .item_i    (item_i),
    .strobe_o  (strobe_o),
    .result_o  (result_o),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // safety net against a hang, set far above what a full 64-point hull needs
  initial begin
    #6000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // called just after a rising edge; returns just after the edge that took the item
  task automatic send_point(input int x, input int y, input bit last);
    bit taken;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start          <= 1'b1;
    item_i.px      <= x[15:0];
    item_i.py      <= y[15:0];
    item_i.last_point <= last;
    // busy only moves at a rising edge, so sample it halfway through the cycle
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    n_sent++;
    // idling profile follows progress: light gaps, then heavy gaps, then none
    idle_pct = (n_sent < 45) ? 8 : (n_sent < 90) ? 57 : 0;
  endtask

  // hold off until the block is idle and every hull vertex has come out,
  // sampled mid-cycle so the edge that took the last item has settled
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (busy || pending != 0);
  endtask

  // narrow coordinates give plenty of collinear and coincident points
  function automatic int pick_coord(bit wide);
    if (wide) return int'($signed($urandom() & 32'hffff) <<< 16) >>> 16;
    return int'($urandom_range(0, 8)) - 4;
  endfunction

  initial begin
    int  set_len;
    bit  wide;
    bit  big_done;
    rst_ni   = 1'b0;
    start    = 1'b0;
    item_i   = '0;
    n_sent   = 0;
    idle_pct = 8;
    big_done = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single point set
    send_point(0, 0, 1'b1);
    // two coincident points collapse to one
    send_point(5, 5, 1'b0);
    send_point(5, 5, 1'b1);
    // all collinear: only the two ends survive
    send_point(2, 2, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(3, 3, 1'b0);
    send_point(1, 1, 1'b1);
    // extreme corners, an interior point and a repeated corner
    send_point(-32768, -32768, 1'b0);
    send_point(32767, -32768, 1'b0);
    send_point(32767, 32767, 1'b0);
    send_point(-32768, 32767, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(32767, 32767, 1'b1);
    // vertical pair, same x
    send_point(7, 1, 1'b0);
    send_point(7, -1, 1'b1);
    // triangle with a point on one edge
    send_point(0, 0, 1'b0);
    send_point(4, 0, 1'b0);
    send_point(2, 0, 1'b0);
    send_point(2, 3, 1'b1);
    // quiet pause with nothing outstanding
    drain();
    @(posedge clk_i);

    // random sets, mostly small; one oversize set fills the store and overflows it
    while (n_sent < 130) begin
      wide = $urandom_range(99) < 40;
      if (!big_done && n_sent > 55) begin
        set_len  = 68;
        big_done = 1'b1;
      end else begin
        set_len = $urandom_range(1, 10);
      end
      for (int i = 0; i < set_len; i++)
        send_point(pick_coord(wide), pick_coord(wide), i == set_len - 1);
      if ($urandom_range(99) < 15) begin
        drain();
        @(posedge clk_i);
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
